### design/bounded_stack_with_keyed_removal_core_assert.svh
// Assertion helpers shared by the stack design files.
`ifndef BOUNDED_STACK_WITH_KEYED_REMOVAL_CORE_ASSERT_SVH
`define BOUNDED_STACK_WITH_KEYED_REMOVAL_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define BSWKR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication outside reset.
`define BSWKR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### design/bswkr_pkg.sv
package bswkr_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CMD_W       = 2;
  localparam int DATA_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_RDATA,
    SRC_KEY
  } res_src_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic     load_req;
    logic     push;
    logic     rd_top;
    logic     rd_down;
    logic     rd_up;
    logic     shift_wr;
    logic     dec_count;
    logic     set_res;
    status_t  res_status;
    res_src_t res_src;
    logic     out_load;
  } ctl_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             empty;
    logic             full;
    logic             match;
    logic             at_top;
    logic             at_bottom;
    logic             out_free;
  } sts_t;

endpackage

### design/bounded_stack_with_keyed_removal_core.sv
// Bounded LIFO stack with push, pop and removal of the topmost matching entry.
// A request is taken only in the idle state. A push, a refused request or an unused
// code is settled in the execute state; a pop reads the top entry, and a removal walks
// the RAM one entry per cycle from the top down to the first match, then shifts the
// entries above it down. No new request is taken until its result moves to the output.
// Reset (synchronous): entry count cleared, no result pending; RAM contents kept.
module bounded_stack_with_keyed_removal_core #(
  parameter int DEPTH = bswkr_pkg::STACK_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bswkr_pkg::CMD_W-1:0]         cmd,
  input  logic signed [bswkr_pkg::DATA_W-1:0] value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bswkr_pkg::STATUS_W-1:0]      status,
  output logic signed [bswkr_pkg::DATA_W-1:0] data_out,
  output logic [bswkr_pkg::COUNT_W-1:0]       count
);

  import bswkr_pkg::*;

  ctl_t ctl;
  sts_t sts;

  bswkr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  bswkr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (value),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .status    (status),
    .data_out  (data_out),
    .count     (count),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule

### design/bswkr_ram.sv
module bswkr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/bswkr_ctrl.sv
`include "bounded_stack_with_keyed_removal_core_assert.svh"

module bswkr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bswkr_pkg::sts_t sts,
  output bswkr_pkg::ctl_t ctl
);

  import bswkr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POPWAIT,
    S_SEARCH,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.res_status = ST_OK;
    ctl.res_src    = SRC_ZERO;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next  = S_DONE;
        ctl.set_res = 1'b1;
        unique case (sts.cmd)
          CMD_PUSH: begin
            if (sts.full) begin
              ctl.res_status = ST_FULL;
            end else begin
              ctl.push = 1'b1;
            end
          end
          CMD_POP: begin
            if (sts.empty) begin
              ctl.res_status = ST_EMPTY;
            end else begin
              ctl.set_res = 1'b0;
              ctl.rd_top  = 1'b1;
              state_next  = S_POPWAIT;
            end
          end
          CMD_REMOVE: begin
            if (sts.empty) begin
              ctl.res_status = ST_EMPTY;
            end else begin
              ctl.set_res = 1'b0;
              ctl.rd_top  = 1'b1;
              state_next  = S_SEARCH;
            end
          end
          default: begin
            // unused code: no operation, ok with zero data
          end
        endcase
      end
      S_POPWAIT: begin
        ctl.set_res   = 1'b1;
        ctl.res_src   = SRC_RDATA;
        ctl.dec_count = 1'b1;
        state_next    = S_DONE;
      end
      S_SEARCH: begin
        if (sts.match) begin
          if (sts.at_top) begin
            ctl.set_res   = 1'b1;
            ctl.res_src   = SRC_KEY;
            ctl.dec_count = 1'b1;
            state_next    = S_DONE;
          end else begin
            ctl.rd_up  = 1'b1;
            state_next = S_SHIFT;
          end
        end else if (sts.at_bottom) begin
          ctl.set_res    = 1'b1;
          ctl.res_status = ST_NOTFOUND;
          state_next     = S_DONE;
        end else begin
          ctl.rd_down = 1'b1;
        end
      end
      S_SHIFT: begin
        // move the entry just read down one place
        ctl.shift_wr = 1'b1;
        if (sts.at_top) begin
          ctl.set_res   = 1'b1;
          ctl.res_src   = SRC_KEY;
          ctl.dec_count = 1'b1;
          state_next    = S_DONE;
        end else begin
          ctl.rd_up = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `BSWKR_ASSERT_IMP(a_load_only_idle, clk, rst, ctl.load_req, state == S_IDLE, "request taken while busy")
  `BSWKR_ASSERT_IMP(a_done_waits, clk, rst, state == S_DONE && !sts.out_free, state_next == S_DONE, "result dropped while output busy")
  `BSWKR_ASSERT(a_one_read, clk, rst, $onehot0({ctl.rd_top, ctl.rd_down, ctl.rd_up}), "conflicting read commands")

endmodule

### design/bswkr_dp.sv
`include "bounded_stack_with_keyed_removal_core_assert.svh"

module bswkr_dp #(
  parameter int DEPTH = bswkr_pkg::STACK_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [bswkr_pkg::CMD_W-1:0]         cmd,
  input  logic signed [bswkr_pkg::DATA_W-1:0] value,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [bswkr_pkg::STATUS_W-1:0]      status,
  output logic signed [bswkr_pkg::DATA_W-1:0] data_out,
  output logic [bswkr_pkg::COUNT_W-1:0]       count,
  input  bswkr_pkg::ctl_t                     ctl,
  output bswkr_pkg::sts_t                     sts
);

  import bswkr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]           entries;
  logic [AW-1:0]           ptr;
  logic signed [DATA_W-1:0] key;
  logic [CMD_W-1:0]        cmd_r;
  status_t                 res_status;
  logic [DATA_W-1:0]       res_data;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic [AW-1:0]     top_addr;

  assign top_addr = AW'(entries - CW'(1));

  assign wr_en   = ctl.push | ctl.shift_wr;
  assign wr_addr = ctl.push ? AW'(entries) : ptr - AW'(1);
  assign wr_data = ctl.push ? key : rd_data;

  assign rd_en   = ctl.rd_top | ctl.rd_down | ctl.rd_up;
  assign rd_addr = ctl.rd_top ? top_addr : (ctl.rd_down ? ptr - AW'(1) : ptr + AW'(1));

  bswkr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign sts.cmd       = cmd_r;
  assign sts.empty     = (entries == '0);
  assign sts.full      = (entries == CW'(DEPTH));
  assign sts.match     = (rd_data == key);
  assign sts.at_top    = ((CW'(ptr) + CW'(1)) == entries);
  assign sts.at_bottom = (ptr == '0);
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.push) begin
        entries <= entries + CW'(1);
      end else if (ctl.dec_count) begin
        entries <= entries - CW'(1);
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_req) begin
      cmd_r <= cmd;
      key   <= value;
    end
    // track the address whose data the RAM returns next
    if (ctl.rd_top) begin
      ptr <= top_addr;
    end else if (ctl.rd_down) begin
      ptr <= ptr - AW'(1);
    end else if (ctl.rd_up) begin
      ptr <= ptr + AW'(1);
    end
    if (ctl.set_res) begin
      res_status <= ctl.res_status;
      case (ctl.res_src)
        SRC_RDATA: res_data <= rd_data;
        SRC_KEY:   res_data <= key;
        default:   res_data <= '0;
      endcase
    end
    if (ctl.out_load) begin
      status   <= res_status;
      data_out <= res_data;
      count    <= COUNT_W'(entries);
    end
  end

  `BSWKR_ASSERT(a_count_bound, clk, rst, entries <= CW'(DEPTH), "entry count above depth")
  `BSWKR_ASSERT_IMP(a_push_room, clk, rst, ctl.push, entries < CW'(DEPTH), "write past the top")
  `BSWKR_ASSERT_IMP(a_dec_nonempty, clk, rst, ctl.dec_count, entries != '0, "drop from empty stack")
  `BSWKR_ASSERT_IMP(a_shift_above, clk, rst, ctl.shift_wr, ptr != '0 && !ctl.push, "shift below the bottom")

endmodule
